>>> rtl/temperature_led_indicator_unit_assert.svh
// assertion macros shared by the temperature led indicator rtl
`ifndef TEMPERATURE_LED_INDICATOR_UNIT_ASSERT_SVH
`define TEMPERATURE_LED_INDICATOR_UNIT_ASSERT_SVH

// antecedent and consequent in the same cycle
`define TLI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("temperature led indicator check failed");

// consequent in the cycle after the antecedent
`define TLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("temperature led indicator check failed");

`endif

>>> rtl/tli_pkg.sv
// types and constants of the temperature led indicator
package tli_pkg;

    typedef struct packed {
        logic [7:0] temperature;
        logic       tick;
    } t_in_word;

    typedef struct packed {
        logic       led_pin2;
        logic       led_pin3;
        logic       led_pin4;
        logic [1:0] room_code;
    } t_out_word;

    // configuration register indexes
    localparam logic [2:0] CFG_SYSTEM_ENABLE  = 3'd0;
    localparam logic [2:0] CFG_LOW_THRESHOLD  = 3'd1;
    localparam logic [2:0] CFG_MID_THRESHOLD  = 3'd2;
    localparam logic [2:0] CFG_HIGH_THRESHOLD = 3'd3;
    localparam logic [2:0] CFG_BREATH_PERIOD  = 3'd4;

    // reset values of the configuration registers
    localparam logic [7:0] LOW_THRESHOLD_RST  = 8'd10;
    localparam logic [7:0] MID_THRESHOLD_RST  = 8'd20;
    localparam logic [7:0] HIGH_THRESHOLD_RST = 8'd30;
    localparam logic [7:0] BREATH_PERIOD_RST  = 8'd22;

    // led level bits: pin 2, pin 3, pin 4
    localparam logic [2:0] LED_PIN2 = 3'b001;
    localparam logic [2:0] LED_PIN3 = 3'b010;
    localparam logic [2:0] LED_PIN4 = 3'b100;
    localparam logic [2:0] LED_OFF  = 3'b000;

    // room state codes
    localparam logic [1:0] ROOM_COOL     = 2'd0;
    localparam logic [1:0] ROOM_WARM     = 2'd1;
    localparam logic [1:0] ROOM_HOT      = 2'd2;
    localparam logic [1:0] ROOM_CRITICAL = 2'd3;

    localparam logic [7:0] TICKS_MAX = 8'd255;

endpackage

>>> rtl/temperature_led_indicator_unit.sv
// temperature led indicator: three-phase led and room-state machine
// Each accepted word (temperature sample plus timer-tick flag) advances the
// idle/evaluate/hold machine once and yields one result word with the three
// led pin levels and the room code. The whole update is one compare-and-add
// pass from the machine registers into the output register, so a word is
// accepted every clock cycle and its result appears in the next cycle; the
// input stalls only while a result waits in the output register and the
// consumer holds off. The user must write thresholds, breathing period and
// enable through the configuration port while the block is idle; not enforced.
module temperature_led_indicator_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tli_pkg::t_in_word     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tli_pkg::t_out_word    o_out_data
);
    import tli_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_EVAL = 2'd1;
    localparam logic [1:0] PH_HOLD = 2'd2;

    logic       r_sys_en;
    logic [7:0] r_low_thr;
    logic [7:0] r_mid_thr;
    logic [7:0] r_high_thr;
    logic [7:0] r_period;

    logic [1:0] r_phase,   n_phase;
    logic [7:0] r_duty,    n_duty;
    logic       r_down,    n_down;
    logic [7:0] r_elapsed, n_elapsed;
    logic [2:0] r_led,     n_led;
    logic [1:0] r_room,    n_room;

    logic       r_out_valid;
    t_out_word  r_out_data;

    logic       in_acc;
    logic       hot;
    logic [7:0] elapsed_cnt;
    logic [7:0] remain;
    logic [7:0] duty_up;
    logic [7:0] duty_dn;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign hot     = i_in_data.temperature >= r_high_thr;
    assign remain  = r_period - r_duty;
    assign duty_up = r_duty + 8'd1;
    assign duty_dn = r_duty - 8'd1;

    always_comb begin
        elapsed_cnt = r_elapsed;
        if (i_in_data.tick && r_elapsed != TICKS_MAX) begin
            elapsed_cnt = r_elapsed + 8'd1;
        end

        n_phase   = r_phase;
        n_duty    = r_duty;
        n_down    = r_down;
        n_elapsed = elapsed_cnt;
        n_led     = r_led;
        n_room    = r_room;

        unique case (r_phase)
            PH_EVAL: begin
                if (!hot && elapsed_cnt != 8'd0) begin
                    n_led = LED_OFF;
                    if (i_in_data.temperature < r_low_thr) begin
                        n_led  = LED_PIN3;
                        n_room = ROOM_COOL;
                    end else if (i_in_data.temperature < r_mid_thr) begin
                        n_led  = LED_PIN4;
                        n_room = ROOM_WARM;
                    end else if (i_in_data.temperature < r_high_thr) begin
                        n_led  = LED_PIN2;
                        n_room = ROOM_HOT;
                    end
                    n_phase = PH_IDLE;
                end else if (hot && elapsed_cnt >= r_duty) begin
                    n_led     = LED_PIN2;
                    n_room    = ROOM_CRITICAL;
                    n_elapsed = 8'd0;
                    n_phase   = PH_HOLD;
                    // one step of the breathing ramp per frame
                    if (!r_down) begin
                        n_duty = duty_up;
                        if (duty_up >= r_period) begin
                            n_down = 1'b1;
                        end
                    end else begin
                        n_duty = duty_dn;
                        if (duty_dn == 8'd0) begin
                            n_down = 1'b0;
                        end
                    end
                end
            end
            PH_HOLD: begin
                if (r_duty >= r_period || elapsed_cnt >= remain) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                // idle, and the unused code behaves as idle
                if (!r_sys_en) begin
                    n_led   = LED_OFF;
                    n_phase = PH_IDLE;
                end else begin
                    n_elapsed = 8'd0;
                    if (hot) begin
                        n_led = r_led | LED_PIN2 | LED_PIN4;
                    end
                    n_phase = PH_EVAL;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_en   <= 1'b0;
            r_low_thr  <= LOW_THRESHOLD_RST;
            r_mid_thr  <= MID_THRESHOLD_RST;
            r_high_thr <= HIGH_THRESHOLD_RST;
            r_period   <= BREATH_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYSTEM_ENABLE:  r_sys_en   <= i_cfg_data[0];
                CFG_LOW_THRESHOLD:  r_low_thr  <= i_cfg_data;
                CFG_MID_THRESHOLD:  r_mid_thr  <= i_cfg_data;
                CFG_HIGH_THRESHOLD: r_high_thr <= i_cfg_data;
                CFG_BREATH_PERIOD:  r_period   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_duty    <= 8'd0;
            r_down    <= 1'b0;
            r_elapsed <= 8'd0;
            r_led     <= LED_OFF;
            r_room    <= ROOM_COOL;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_duty    <= n_duty;
            r_down    <= n_down;
            r_elapsed <= n_elapsed;
            r_led     <= n_led;
            r_room    <= n_room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data.led_pin2  <= |(n_led & LED_PIN2);
            r_out_data.led_pin3  <= |(n_led & LED_PIN3);
            r_out_data.led_pin4  <= |(n_led & LED_PIN4);
            r_out_data.room_code <= n_room;
        end
    end

`include "temperature_led_indicator_unit_assert.svh"

    `TLI_ASSERT_NEXT(a_word_gives_result, i_clk, i_rst_n, in_acc, r_out_valid)
    `TLI_ASSERT_NEXT(a_disabled_dark, i_clk, i_rst_n, in_acc && r_phase == PH_IDLE && !r_sys_en, r_phase == PH_IDLE && r_led == LED_OFF)
    `TLI_ASSERT_SAME(a_hold_is_critical, i_clk, i_rst_n, r_phase == PH_HOLD, r_room == ROOM_CRITICAL)
    `TLI_ASSERT_NEXT(a_ticks_saturate, i_clk, i_rst_n, in_acc && r_phase == PH_HOLD && r_elapsed == TICKS_MAX, r_elapsed == TICKS_MAX)

endmodule
